>>> rtl/plcl_pkg.sv
// Package: constants, types and status codes of the curve lookup block.
`default_nettype none
package plcl_pkg;
    localparam int MaxPoints = 64;
    localparam int QuotCapBit = 50;

    typedef enum logic [2:0] {
        ST_INSIDE = 3'd0,
        ST_BELOW  = 3'd1,
        ST_ABOVE  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_SINGLE = 3'd4,
        ST_FAIL   = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        FN_LOAD  = 1'b0,
        FN_QUERY = 1'b1
    } t_func;

    typedef struct packed {
        logic [0:0]         func;
        logic [5:0]         point_index;
        logic signed [31:0] strain;
        logic signed [31:0] stress_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] stress_out;
        logic signed [47:0] slope_out;
        t_status            status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_FIRST, S_WT_FIRST, S_RD_LAST, S_WT_LAST, S_SCAN_RD, S_SCAN_WT,
        S_SEG_RD, S_SEG_LO, S_SEG_WT, S_MUL, S_DIV1, S_DIV2, S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/plcl_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface plcl_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/plcl_front.sv
// Front part: accepts items and holds them in a short queue for the back part.
`default_nettype none
module plcl_front (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plcl_if.sink       s_in,
    plcl_if.source     m_q
);
    localparam int Depth = 2;
    plcl_pkg::t_in_item r_mem [Depth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign s_in.ready = (r_cnt != 2'(Depth));
    assign m_q.valid  = (r_cnt != 2'd0);
    assign m_q.data   = r_mem[r_rp];
    assign w_push = s_in.valid && s_in.ready;
    assign w_pop  = m_q.valid && m_q.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= s_in.data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/plcl_divider.sv
// Restoring divider: one quotient bit a cycle, quotient capped at 2^50.
`default_nettype none
module plcl_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [87:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [50:0]      o_quot
);
    localparam int Cap = plcl_pkg::QuotCapBit;
    logic [87:0] r_num;
    logic [33:0] r_rem;
    logic [50:0] r_q;
    logic        r_sat, r_busy;
    logic [6:0]  r_cnt;
    logic [33:0] w_sh;
    logic        w_ge;
    logic [51:0] w_nq;

    assign w_sh = {r_rem[32:0], r_num[87]};
    assign w_ge = w_sh >= {1'b0, i_den};
    assign w_nq = {r_q, w_ge};
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign o_quot = r_sat ? 51'(1) << Cap : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= 7'd88; r_num <= i_num;
            r_rem <= '0; r_q <= '0; r_sat <= 1'b0;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
            r_num <= {r_num[86:0], 1'b0};
            r_rem <= w_ge ? w_sh - {1'b0, i_den} : w_sh;
            if (!r_sat) begin
                r_q <= w_nq[50:0];
                if (w_nq[51] || w_nq[50]) r_sat <= 1'b1;
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/plcl_back.sv
// Back part: breakpoint memory, segment search and interpolation sequencer.
`default_nettype none
module plcl_back #(
    parameter int MAX_POINTS = plcl_pkg::MaxPoints
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [6:0] i_num_points,
    plcl_if.sink      s_q,
    plcl_if.source    m_out
);
    localparam int Aw = (MAX_POINTS > 64) ? $clog2(MAX_POINTS) : 6;
    localparam int Cw = Aw + 1;

    logic [31:0] r_mem_s [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];
    logic [31:0] r_rd_s, r_rd_y;
    logic [Aw-1:0] w_addr;

    plcl_pkg::t_state r_st, n_st;
    logic [Cw-1:0] r_n, r_i;
    logic signed [31:0] r_x;
    logic signed [31:0] r_s0, r_y0, r_prev;
    logic [Aw-1:0] r_seg;
    plcl_pkg::t_status r_status;
    logic r_neg1, r_neg2;
    logic [63:0] w_prod;
    logic [32:0] r_dep;
    logic [32:0] r_dsy;
    logic signed [32:0] r_dx;
    plcl_pkg::t_out_item r_out;
    logic r_ov;
    logic signed [33:0] w_dep_s, w_dsy_s;

    logic w_dstart, w_ddone;
    logic [87:0] w_num;
    logic [50:0] w_quot;

    plcl_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_num),
        .i_den(r_dep), .o_done(w_ddone), .o_quot(w_quot)
    );

    logic w_load;
    logic [Cw-1:0] w_eff_n;
    assign w_eff_n = (Cw'(i_num_points) > Cw'(MAX_POINTS)) ? Cw'(MAX_POINTS) : Cw'(i_num_points);
    assign w_load = s_q.valid && r_st == plcl_pkg::S_IDLE
                    && s_q.data.func == plcl_pkg::FN_LOAD;
    assign s_q.ready = (r_st == plcl_pkg::S_IDLE) && !r_ov;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;

    always_comb begin
        case (r_st)
            plcl_pkg::S_RD_FIRST: w_addr = '0;
            plcl_pkg::S_RD_LAST:  w_addr = Aw'(r_n - Cw'(1));
            plcl_pkg::S_SEG_RD:   w_addr = r_seg;
            plcl_pkg::S_SEG_LO:   w_addr = r_seg + Aw'(1);
            default:              w_addr = Aw'(r_i);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !r_ov && Cw'(s_q.data.point_index) < Cw'(MAX_POINTS)) begin
            r_mem_s[Aw'(s_q.data.point_index)] <= s_q.data.strain;
            r_mem_y[Aw'(s_q.data.point_index)] <= s_q.data.stress_value;
        end
        r_rd_s <= r_mem_s[w_addr];
        r_rd_y <= r_mem_y[w_addr];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            plcl_pkg::S_IDLE:
                if (s_q.valid && !r_ov && s_q.data.func == plcl_pkg::FN_QUERY) begin
                    n_st = (w_eff_n == '0) ? plcl_pkg::S_DONE : plcl_pkg::S_RD_FIRST;
                end
            plcl_pkg::S_RD_FIRST: n_st = plcl_pkg::S_WT_FIRST;
            plcl_pkg::S_WT_FIRST:
                if (r_n == Cw'(1)) n_st = plcl_pkg::S_DONE;
                else if ($signed(r_rd_s) > r_x) n_st = plcl_pkg::S_SEG_RD;
                else n_st = plcl_pkg::S_RD_LAST;
            plcl_pkg::S_RD_LAST: n_st = plcl_pkg::S_WT_LAST;
            plcl_pkg::S_WT_LAST:
                n_st = (r_x > $signed(r_rd_s)) ? plcl_pkg::S_SEG_RD : plcl_pkg::S_SCAN_RD;
            plcl_pkg::S_SCAN_RD: n_st = plcl_pkg::S_SCAN_WT;
            plcl_pkg::S_SCAN_WT:
                if (r_x >= r_prev && r_x <= $signed(r_rd_s)) n_st = plcl_pkg::S_SEG_RD;
                else if (r_i + Cw'(1) >= r_n) n_st = plcl_pkg::S_DONE;
                else n_st = plcl_pkg::S_SCAN_RD;
            plcl_pkg::S_SEG_RD: n_st = plcl_pkg::S_SEG_LO;
            plcl_pkg::S_SEG_LO: n_st = plcl_pkg::S_SEG_WT;
            plcl_pkg::S_SEG_WT:
                n_st = ($signed(r_rd_s) == r_s0) ? plcl_pkg::S_DONE : plcl_pkg::S_MUL;
            plcl_pkg::S_MUL:  n_st = plcl_pkg::S_DIV1;
            plcl_pkg::S_DIV1: if (w_ddone) n_st = plcl_pkg::S_DIV2;
            plcl_pkg::S_DIV2: if (w_ddone) n_st = plcl_pkg::S_DONE;
            plcl_pkg::S_DONE: n_st = plcl_pkg::S_IDLE;
            default: n_st = plcl_pkg::S_IDLE;
        endcase
    end

    assign w_prod = 64'((r_dx[32] ? 33'(-r_dx) : 33'(r_dx))) * 64'(r_dsy);
    assign w_dstart = (r_st == plcl_pkg::S_MUL) || (r_st == plcl_pkg::S_DIV1 && w_ddone);
    assign w_num = (r_st == plcl_pkg::S_MUL) ? {24'd0, w_prod} : {31'd0, r_dsy, 24'd0};
    assign w_dep_s = 34'($signed(r_rd_s)) - 34'(r_s0);
    assign w_dsy_s = 34'($signed(r_rd_y)) - 34'(r_y0);

    logic signed [52:0] w_sq;
    logic signed [52:0] w_ssum;
    assign w_sq = r_neg1 ? -$signed({2'b0, w_quot}) : $signed({2'b0, w_quot});
    assign w_ssum = 53'(r_y0) + w_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= plcl_pkg::S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (m_out.valid && m_out.ready) r_ov <= 1'b0;
            if (r_st == plcl_pkg::S_DONE) r_ov <= 1'b1;
        end
        case (r_st)
            plcl_pkg::S_IDLE: begin
                r_n <= w_eff_n; r_x <= s_q.data.strain; r_i <= Cw'(1);
                // hold the waiting result
                if (!r_ov) begin
                    r_out.stress_out <= 32'sh7FFFFFFF; r_out.slope_out <= '0;
                    r_out.status <= plcl_pkg::ST_EMPTY;
                end
            end
            plcl_pkg::S_WT_FIRST: begin
                r_s0 <= r_rd_s; r_y0 <= r_rd_y; r_seg <= '0; r_prev <= r_rd_s;
                if (r_n == Cw'(1)) begin
                    r_out.stress_out <= r_rd_y; r_out.status <= plcl_pkg::ST_SINGLE;
                end else begin
                    r_out.stress_out <= '0; r_out.status <= plcl_pkg::ST_BELOW;
                end
            end
            plcl_pkg::S_WT_LAST:
                if (r_x > $signed(r_rd_s)) begin
                    r_out.status <= plcl_pkg::ST_ABOVE;
                    r_seg <= Aw'(r_n - Cw'(2));
                    r_i <= Cw'(r_n - Cw'(2));
                end
            plcl_pkg::S_SCAN_WT: begin
                r_out.status <= plcl_pkg::ST_FAIL;
                r_prev <= r_rd_s;
                r_i <= r_i + Cw'(1);
                if (r_x >= r_prev && r_x <= $signed(r_rd_s)) begin
                    r_out.status <= plcl_pkg::ST_INSIDE;
                    r_seg <= Aw'(r_i - Cw'(1));
                    r_i <= r_i - Cw'(1);
                end
            end
            plcl_pkg::S_SEG_RD: r_i <= Cw'(r_seg);
            plcl_pkg::S_SEG_LO: begin
                // lower point of the segment; the upper one is read in S_SEG_WT
                r_s0 <= r_rd_s; r_y0 <= r_rd_y;
            end
            plcl_pkg::S_SEG_WT: begin
                if ($signed(r_rd_s) == r_s0) r_out.status <= plcl_pkg::ST_FAIL;
                r_dep <= w_dep_s[33] ? 33'(-w_dep_s) : 33'(w_dep_s);
                r_dsy <= w_dsy_s[33] ? 33'(-w_dsy_s) : 33'(w_dsy_s);
                r_dx  <= 33'(r_x) - 33'(r_s0);
                r_neg2 <= w_dsy_s[33] != w_dep_s[33];
                r_neg1 <= (r_x < r_s0) != (w_dsy_s[33] != w_dep_s[33]);
            end
            plcl_pkg::S_DIV1:
                if (w_ddone) begin
                    if (w_ssum > 53'sh7FFFFFFF) r_out.stress_out <= 32'sh7FFFFFFF;
                    else if (w_ssum < -53'sh80000000) r_out.stress_out <= 32'sh80000000;
                    else r_out.stress_out <= 32'(w_ssum);
                end
            plcl_pkg::S_DIV2:
                if (w_ddone) begin
                    if (w_quot > 51'h7FFFFFFFFFFF)
                        r_out.slope_out <= r_neg2 ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
                    else
                        r_out.slope_out <= r_neg2 ? -48'(w_quot) : 48'(w_quot);
                end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/piecewise_linear_curve_lookup.sv
// Piecewise linear curve lookup: front queue, back search/interpolate sequencer.
// Usage: the input channel carries load items (func 0: write breakpoint
// point_index with strain and stress_value) and queries (func 1: strain).
// A load yields no result; a query yields one item with stress_out,
// slope_out and status on the output channel. The user writes num_points
// through i_cfg_we / i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. A load passes through the input queue and
// is written to the breakpoint memory when the back part takes it. A query
// searches the breakpoints for its segment and, for a valid segment,
// interpolates with two restoring divisions in one shared divider.
// Items are processed one at a time.
// A two-entry queue at the input takes items while the back part works.
// Reset clears num_points, the queue and the sequencer; the breakpoint
// memory holds no reset value. When the receiver stalls, the result waits
// in the output register and the back part takes no new item.
`default_nettype none
module piecewise_linear_curve_lookup #(
    parameter int MAX_POINTS = plcl_pkg::MaxPoints
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    plcl_if.sink            s_in,
    plcl_if.source          m_out
);
    logic [6:0] r_num_points;
    plcl_if #(.T(plcl_pkg::t_in_item)) q_if ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_num_points <= 7'd0;
        else if (i_cfg_we) r_num_points <= i_cfg_wdata;
    end

    plcl_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_q(q_if));
    plcl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num_points(r_num_points),
        .s_q(q_if), .m_out(m_out)
    );
endmodule
`default_nettype wire

>>> dv/plcl_checker.sv
// Checker of the curve lookup block: watches both channels, predicts each query and compares.
`timescale 1ns / 1ps
module plcl_checker
    import plcl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  t_in_item        i_in_data,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  t_out_item       i_out_data,
    output int              o_errors,
    output int              o_pending
);
    logic [6:0]         point_count;
    logic signed [31:0] knot_strain [MaxPoints];
    logic signed [31:0] knot_stress [MaxPoints];
    t_out_item          curve_results [$];

    function automatic longint sat_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic t_out_item lookup_curve(logic signed [31:0] x);
        t_out_item   r;
        int          n;
        int          seg;
        longint      s0, s1, y0, y1, dep, dx, dsy, q, stress, slope;
        logic [127:0] prod;
        logic [127:0] quot;
        bit          neg;
        n = point_count > MaxPoints ? MaxPoints : int'(point_count);
        stress = 0;
        slope = 0;
        seg = 0;
        if (n == 0) begin
            stress = 64'sh7FFF_FFFF;
            r.status = ST_EMPTY;
        end else if (n == 1) begin
            stress = knot_stress[0];
            r.status = ST_SINGLE;
        end else begin
            r.status = ST_FAIL;
            if (x < knot_strain[0]) begin
                r.status = ST_BELOW;
            end else if (x > knot_strain[n-1]) begin
                r.status = ST_ABOVE;
                seg = n - 2;
            end else begin
                for (int i = 0; i + 1 < n; i++) begin
                    if (x >= knot_strain[i] && x <= knot_strain[i+1]) begin
                        r.status = ST_INSIDE;
                        seg = i;
                        break;
                    end
                end
            end
            if (r.status != ST_FAIL) begin
                s0 = knot_strain[seg];
                s1 = knot_strain[seg+1];
                y0 = knot_stress[seg];
                y1 = knot_stress[seg+1];
                dep = s1 - s0;
                if (dep == 0) begin
                    r.status = ST_FAIL;
                end else begin
                    dx = x - s0;
                    dsy = y1 - y0;
                    neg = ((dx < 0) != (dsy < 0)) != (dep < 0);
                    prod = 128'(dx < 0 ? -dx : dx) * 128'(dsy < 0 ? -dsy : dsy);
                    quot = prod / 128'(dep < 0 ? -dep : dep);
                    // clamp the quotient the way the divider does
                    if (quot >= (128'd1 << QuotCapBit)) quot = 128'd1 << QuotCapBit;
                    q = longint'(quot[63:0]);
                    stress = sat_to(y0 + (neg ? -q : q), 32);
                    neg = (dsy < 0) != (dep < 0);
                    q = ((dsy < 0 ? -dsy : dsy) <<< 24) / (dep < 0 ? -dep : dep);
                    slope = sat_to(neg ? -q : q, 48);
                end
            end
        end
        r.stress_out = stress[31:0];
        r.slope_out = slope[47:0];
        return r;
    endfunction

    assign o_pending = curve_results.size();

    always @(posedge i_clk) begin
        t_out_item want;
        int        bad;
        bad = 0;
        if (!i_rst_n) begin
            point_count <= '0;
            curve_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) point_count <= i_cfg_wdata;
            // compare before pushing: a query accepted now cannot be answered in this cycle
            if (i_out_valid && i_out_ready) begin
                if (curve_results.size() == 0) begin
                    $error("unexpected result transaction: %p", i_out_data);
                    bad++;
                end else begin
                    want = curve_results.pop_front();
                    if (want.stress_out !== i_out_data.stress_out) begin
                        $error("stress_out: expected %0d, got %0d",
                            want.stress_out, i_out_data.stress_out);
                        bad++;
                    end
                    if (want.slope_out !== i_out_data.slope_out) begin
                        $error("slope_out: expected %0d, got %0d",
                            want.slope_out, i_out_data.slope_out);
                        bad++;
                    end
                    if (want.status !== i_out_data.status) begin
                        $error("status: expected %0d, got %0d",
                            want.status, i_out_data.status);
                        bad++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.func == FN_LOAD) begin
                    knot_strain[i_in_data.point_index] <= i_in_data.strain;
                    knot_stress[i_in_data.point_index] <= i_in_data.stress_value;
                end else begin
                    curve_results.push_back(lookup_curve(i_in_data.strain));
                end
            end
            o_errors <= o_errors + bad;
        end
    end
endmodule

>>> dv/tb_piecewise_linear_curve_lookup.sv
// Testbench top of the curve lookup block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_piecewise_linear_curve_lookup;
    import plcl_pkg::*;

    localparam int ItemTarget = 550;
    localparam int QuietAfter = 480;
    localparam int LongHold = 1500;
    localparam int StallLimit = 6000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    int         errors;
    int         pending;
    int         items_sent;
    bit         quiet;
    bit         long_hold_req;
    bit         run_done;
    logic signed [31:0] knot_strain [MaxPoints];

    plcl_if #(.T(t_in_item))  in_ch ();
    plcl_if #(.T(t_out_item)) out_ch ();

    piecewise_linear_curve_lookup u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .s_in        (in_ch),
        .m_out       (out_ch)
    );

    plcl_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one transaction; gaps come in bursts.
    task automatic offer(input t_in_item item);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic load_point(input int slot, input logic signed [31:0] s,
                              input logic signed [31:0] y);
        t_in_item item;
        item.func = FN_LOAD;
        item.point_index = 6'(slot);
        item.strain = s;
        item.stress_value = y;
        knot_strain[slot] = s;
        offer(item);
    endtask

    task automatic query_at(input logic signed [31:0] x);
        t_in_item item;
        item.func = FN_QUERY;
        item.point_index = 6'($urandom);
        item.strain = x;
        item.stress_value = $urandom;
        offer(item);
    endtask

    // Drain, let a trailing load settle, then write the point count.
    task automatic set_point_count(input logic [6:0] v);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_table(input int n);
        logic signed [31:0] s [MaxPoints];
        logic signed [31:0] t;
        int mode;
        int big_stress;
        mode = $urandom_range(0, 9);
        big_stress = $urandom_range(0, 2) == 0;
        for (int i = 0; i < n; i++) begin
            if (mode < 4) s[i] = $urandom;
            else if (i == 0) s[i] = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
            else s[i] = s[i-1] + $urandom_range(0, 4096);
        end
        // sort most tables, leave some unsorted
        if (mode != 9) begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j + 1 < n - i; j++)
                    if (s[j] > s[j+1]) begin
                        t = s[j];
                        s[j] = s[j+1];
                        s[j+1] = t;
                    end
        end
        if (mode == 8 && n > 1) s[$urandom_range(1, n - 1)] = s[0];
        for (int i = 0; i < n; i++)
            load_point(i, s[i], big_stress ? $urandom
                                : $signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endtask

    task automatic random_query(input int n);
        int k;
        int kind;
        logic signed [31:0] x;
        k = n > 0 ? $urandom_range(0, n - 1) : 0;
        kind = $urandom_range(0, 5);
        case (kind)
            0: x = $urandom;
            1: x = knot_strain[k];
            2, 3: x = knot_strain[k] + $signed($urandom_range(0, 8192)) - 4096;
            4: x = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: x = knot_strain[k] + $signed($urandom_range(0, 1 << 20));
        endcase
        if (n == 0) x = $urandom;
        query_at(x);
    endtask

    initial begin
        int n;
        int eff;
        int phase;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        items_sent = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table straight out of reset
        query_at(32'sh8000_0000);
        query_at(32'sh7FFF_FFFF);
        query_at(0);
        // single point
        load_point(0, 32'sh0100_0000, 32'sh8000_0000);
        set_point_count(7'd1);
        query_at(32'sh7FFF_FFFF);
        // steepest segment: stress saturates both ways and slope saturates high
        load_point(0, 0, 32'sh8000_0000);
        load_point(1, 1, 32'sh7FFF_FFFF);
        set_point_count(7'd2);
        query_at(32'sh7FFF_FFFF);
        query_at(32'sh8000_0000);
        query_at(0);
        query_at(1);
        load_point(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        load_point(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query_at(0);
        query_at(32'sh7FFF_FFFF);
        // zero-length segment
        load_point(1, 32'sh8000_0000, 0);
        query_at(32'sh8000_0000);
        query_at(5);

        phase = 0;
        while (items_sent < ItemTarget) begin
            case (phase)
                0: n = 64;
                1: n = 127;
                2: n = 0;
                default: begin
                    case ($urandom_range(0, 9))
                        0: n = 1;
                        1: n = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
                        2: n = 0;
                        default: n = $urandom_range(2, 8);
                    endcase
                end
            endcase
            eff = n > MaxPoints ? MaxPoints : n;
            if (phase != 1) fill_table(eff);
            set_point_count(7'(n));
            if (phase == 0) long_hold_req = 1'b1;
            if (items_sent > QuietAfter) quiet = 1'b1;
            repeat ($urandom_range(6, 20)) begin
                // stray loads into slots past the count never reach a query
                if (eff < MaxPoints && $urandom_range(0, 7) == 0)
                    load_point($urandom_range(eff, MaxPoints - 1), $urandom, $urandom);
                else
                    random_query(eff);
            end
            phase++;
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        run_done = 1'b1;
        if (errors == 0)
            $display("tb_piecewise_linear_curve_lookup: clean");
        else
            $display("tb_piecewise_linear_curve_lookup: errors");
        $finish;
    end

    // Receiver: random stalls, one long hold while the sender keeps offering.
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_req && !held) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < StallLimit) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (!run_done) begin
            $display("tb_piecewise_linear_curve_lookup: errors");
            $finish;
        end
    end
endmodule
